// ===== src/imds_pkg.sv =====
// shared types and constants for the 2x2 box-average downscaler
// no dependencies; imported by image_downscale_2x_box_average_core
`timescale 1ns / 1ps
`default_nettype none

package imds_pkg;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ODD_START  = 2'd2;

  localparam int unsigned SRC_WIDTH_W  = 12;
  localparam int unsigned SRC_HEIGHT_W = 13;
  localparam int unsigned PIXEL_W      = 8;
  localparam int unsigned PAIR_SUM_W   = 9;

  localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = 12'd640;
  localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = 13'd480;

  // item waiting in the read stage for its line store read
  typedef struct packed {
    logic [PAIR_SUM_W-1:0] sum;
    logic                  single;
    logic                  row_last;
    logic                  frame_last;
  } avg_stage_t;

endpackage

`default_nettype wire

// ===== src/image_downscale_2x_box_average_core.sv =====
// 2x2 box-average downscaler: the beat that completes a block goes through the
// line store read, then the output register, to the result beat. throughput
// one source pixel per clock unless the output stalls; the single-port-per-
// direction line store gives one access per beat, so it never stalls by itself.
// reset loads the register defaults (640 x 480, even start) and clears the
// counters; the line store is not cleared, every entry is written before read.
// depends on imds_pkg
`timescale 1ns / 1ps
`default_nettype none

module image_downscale_2x_box_average_core #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [3:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output      logic [31:0]                        prdata,
  output      logic                               pready,
  // source pixels
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [imds_pkg::PIXEL_W-1:0]       pixel_i,
  // destination pixels
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [imds_pkg::PIXEL_W-1:0]       out_pixel_o,
  output      logic                               row_last_o,
  output      logic                               frame_last_o
);
  import imds_pkg::*;

  localparam int unsigned STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CIW = $clog2(MAX_WIDTH);
  localparam int unsigned RIW = $clog2(MAX_HEIGHT);
  localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW  = (WB > SRC_WIDTH_W) ? WB : SRC_WIDTH_W;
  localparam int unsigned HW  = (HB > SRC_HEIGHT_W) ? HB : SRC_HEIGHT_W;
  localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);
  localparam logic [HW-1:0] MAX_H_C = HW'(MAX_HEIGHT);

  // configuration registers
  logic [SRC_WIDTH_W-1:0]  src_width_q;
  logic [SRC_HEIGHT_W-1:0] src_height_q;
  logic                    odd_start_q;
  logic                    cfg_we;
  logic                    cfg_hit;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    case (paddr[3:2])
      REG_SRC_WIDTH: begin
        cfg_hit = cfg_we;
        prdata  = 32'(src_width_q);
      end
      REG_SRC_HEIGHT: begin
        cfg_hit = cfg_we;
        prdata  = 32'(src_height_q);
      end
      REG_ODD_START: begin
        cfg_hit = cfg_we;
        prdata  = 32'(odd_start_q);
      end
      default: begin
        cfg_hit = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_WIDTH_RST;
      src_height_q <= SRC_HEIGHT_RST;
      odd_start_q  <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_WIDTH_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SRC_HEIGHT_W-1:0];
        REG_ODD_START:  odd_start_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // effective region size, zero taken as one and clamped to the maximum
  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    eff_w = CW'(src_width_q);
    if (src_width_q == '0) eff_w = CW'(1);
    else if (CW'(src_width_q) > MAX_W_C) eff_w = MAX_W_C;
    eff_h = HW'(src_height_q);
    if (src_height_q == '0) eff_h = HW'(1);
    else if (HW'(src_height_q) > MAX_H_C) eff_h = MAX_H_C;
  end

  // position counters and the first pixel of a horizontal pair
  logic [CIW-1:0]     col_q, col_d;
  logic [RIW-1:0]     row_q, row_d;
  logic [PIXEL_W-1:0] held_q, held_d;

  logic              accept;
  logic              w_odd, off;
  logic [CIW:0]      pos;
  logic [AW-1:0]     addr;
  logic              at_end, row_wrap, single, completes, is_odd_row;
  logic              fr_last;
  logic [HW-1:0]     full_rows;
  logic [PAIR_SUM_W-1:0] sum;

  assign accept     = in_valid_i & in_ready_o;
  assign w_odd      = eff_w[0];
  assign off        = odd_start_q & w_odd;
  assign pos        = (CIW+1)'(col_q) + (CIW+1)'(off);
  assign addr       = AW'(pos >> 1);
  assign at_end     = ((CW+1)'(col_q) + (CW+1)'(1)) >= (CW+1)'(eff_w);
  assign row_wrap   = ((HW+1)'(row_q) + (HW+1)'(1)) >= (HW+1)'(eff_h);
  assign single     = (off & (col_q == '0)) | (~off & w_odd & at_end);
  assign completes  = single | pos[0] | at_end;
  assign is_odd_row = row_q[0];
  assign full_rows  = eff_h & ~HW'(1);
  assign fr_last    = at_end & (((HW+1)'(row_q) + (HW+1)'(1)) == (HW+1)'(full_rows));
  assign sum        = single ? PAIR_SUM_W'(pixel_i)
                             : PAIR_SUM_W'(held_q) + PAIR_SUM_W'(pixel_i);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      held_d = '0;
    end else if (accept) begin
      held_d = completes ? '0 : pixel_i;
      if (at_end) begin
        col_d  = '0;
        held_d = '0;
        row_d  = row_wrap ? '0 : row_q + RIW'(1);
      end else begin
        col_d = col_q + CIW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      held_q <= held_d;
    end
  end

  // line store of pair sums: written on even rows, read on odd rows
  logic [PAIR_SUM_W-1:0] pair_mem [STORE_DEPTH];
  logic [PAIR_SUM_W-1:0] rd_q;
  logic                  mem_we, mem_re;

  assign mem_we = accept & completes & ~is_odd_row;
  assign mem_re = accept & completes & is_odd_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) pair_mem[addr] <= sum;
    if (mem_re) rd_q <= pair_mem[addr];
  end

  // read stage and output register
  logic       s1_valid_q, s1_valid_d;
  avg_stage_t s1_q;
  logic       out_valid_q, out_valid_d;
  logic       s1_adv, s1_move;
  logic [PAIR_SUM_W:0] total;
  logic [PIXEL_W-1:0]  avg;
  logic [PIXEL_W-1:0]  out_pixel_q;
  logic                row_last_q, frame_last_q;

  assign s1_adv     = ~out_valid_q | out_ready_i;
  assign s1_move    = s1_valid_q & s1_adv;
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign s1_valid_d = in_ready_o ? mem_re : s1_valid_q;
  assign out_valid_d = s1_move | (out_valid_q & ~out_ready_i);

  assign total = (PAIR_SUM_W+1)'(rd_q) + (PAIR_SUM_W+1)'(s1_q.sum);
  assign avg   = s1_q.single ? total[PIXEL_W:1] : total[PIXEL_W+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_q.sum        <= sum;
      s1_q.single     <= single;
      s1_q.row_last   <= at_end;
      s1_q.frame_last <= fr_last;
    end
    if (s1_move) begin
      out_pixel_q  <= avg;
      row_last_q   <= s1_q.row_last;
      frame_last_q <= s1_q.frame_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign row_last_o   = row_last_q;
  assign frame_last_o = frame_last_q;

endmodule

`default_nettype wire

// ===== bench/tb_image_downscale_2x_box_average_core.sv =====
// testbench for image_downscale_2x_box_average_core: random pixel frames, random stalls,
// apb register changes between frames, results checked against an in-bench predictor
// depends on imds_pkg and the core rtl
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] pix;
  logic       row_last;
  logic       frame_last;
} dest_beat_t;

class downscale_scoreboard;
  localparam int unsigned MAX_W      = 2048;
  localparam int unsigned MAX_H      = 4096;
  localparam int unsigned LINE_DEPTH = MAX_W / 2;

  bit [11:0]   width_reg;
  bit [12:0]   height_reg;
  bit          odd_reg;
  bit [8:0]    line_sums [LINE_DEPTH];
  int unsigned col;
  int unsigned row;
  int unsigned held;
  dest_beat_t  expected_q [$];
  int          errors;

  function new();
    width_reg  = imds_pkg::SRC_WIDTH_RST;
    height_reg = imds_pkg::SRC_HEIGHT_RST;
    odd_reg    = 1'b0;
    errors     = 0;
    restart();
  endfunction

  function void restart();
    col  = 0;
    row  = 0;
    held = 0;
  endfunction

  function int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  function int unsigned frame_size();
    return eff_width() * eff_height();
  endfunction

  // unused indexes change nothing and keep the frame position
  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      imds_pkg::REG_SRC_WIDTH:  width_reg  = data[11:0];
      imds_pkg::REG_SRC_HEIGHT: height_reg = data[12:0];
      imds_pkg::REG_ODD_START:  odd_reg    = data[0];
      default: return;
    endcase
    restart();
  endfunction

  function void note_pixel(logic [7:0] px);
    int unsigned w, h, off, p, k, sum, total;
    bit          w_odd, at_end, single;
    dest_beat_t  beat;
    w      = eff_width();
    h      = eff_height();
    w_odd  = w[0];
    off    = (odd_reg && w_odd) ? 1 : 0;
    p      = col + off;
    k      = (p >> 1) % LINE_DEPTH;
    at_end = (col + 1 >= w);
    single = (off != 0 && col == 0) || (off == 0 && w_odd && at_end);
    if (single || p[0] || at_end) begin
      sum = single ? px : held + px;
      if (!row[0]) begin
        line_sums[k] = sum[8:0];
      end else begin
        total           = line_sums[k] + sum;
        beat.pix        = single ? 8'(total >> 1) : 8'(total >> 2);
        beat.row_last   = at_end;
        beat.frame_last = at_end && (row + 1 == (h & ~32'd1));
        expected_q.push_back(beat);
      end
      held = 0;
    end else begin
      held = px;
    end
    if (at_end) begin
      col  = 0;
      held = 0;
      row  = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col++;
    end
  endfunction

  function void check_beat(logic [7:0] pix, logic row_last, logic frame_last);
    dest_beat_t exp_beat;
    if (expected_q.size() == 0) begin
      $error("unexpected output beat: out_pixel %0d", pix);
      errors++;
      return;
    end
    exp_beat = expected_q.pop_front();
    if (pix !== exp_beat.pix) begin
      $error("out_pixel: expected %0d, got %0d", exp_beat.pix, pix);
      errors++;
    end
    if (row_last !== exp_beat.row_last) begin
      $error("row_last: expected %0d, got %0d", exp_beat.row_last, row_last);
      errors++;
    end
    if (frame_last !== exp_beat.frame_last) begin
      $error("frame_last: expected %0d, got %0d", exp_beat.frame_last, frame_last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_image_downscale_2x_box_average_core;
  import imds_pkg::*;

  localparam int unsigned  MAX_W         = 2048;
  localparam int unsigned  MAX_H         = 4096;
  localparam logic [1:0]   REG_UNUSED    = 2'd3;
  localparam int unsigned  SETTLE_CYCLES = 8;
  localparam int unsigned  RANDOM_ITEMS  = 800;
  localparam longint       CYCLE_LIMIT   = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  pixel_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_pixel_o;
  logic        row_last_o;
  logic        frame_last_o;

  downscale_scoreboard sb;
  bit     no_idle;
  longint cycles;

  image_downscale_2x_box_average_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .row_last_o  (row_last_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_beat(out_pixel_o, row_last_o, frame_last_o);
    end
  end

  // receiver: random stall before each beat
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // register fields keep their value, the unused bits get noise
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] data;
    data = $urandom;
    case (idx)
      REG_SRC_WIDTH:  data[11:0] = val[11:0];
      REG_SRC_HEIGHT: data[12:0] = val[12:0];
      REG_ODD_START:  data[0]    = val[0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      pixel_i    <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(px);
  endtask

  // stop sending, wait for every result, then let the pipeline empty
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_pixel(rand_pixel());
      if ($urandom_range(0, 59) == 0) drain_results();
    end
  endtask

  initial begin
    int unsigned fsize, nframes, count, random_sent;
    logic [11:0] w_pick;
    logic [12:0] h_pick;
    sb          = new();
    cycles      = 0;
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: one full row of 640 plus the start of the next
    send_random(640 + 16);
    drain_results();

    // odd width, single column on the right, all white
    reg_write(REG_SRC_WIDTH, 32'd3);
    reg_write(REG_SRC_HEIGHT, 32'd2);
    reg_write(REG_ODD_START, 32'd0);
    repeat (6) send_pixel(8'hFF);
    drain_results();
    // odd width, single column on the left
    reg_write(REG_ODD_START, 32'd1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd3);
    send_pixel(8'd254);
    send_pixel(8'd255);
    drain_results();
    // trailing odd row is consumed silently
    reg_write(REG_SRC_WIDTH, 32'd2);
    reg_write(REG_SRC_HEIGHT, 32'd3);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd7);
    send_pixel(8'd9);
    drain_results();
    // height one gives nothing
    reg_write(REG_SRC_HEIGHT, 32'd1);
    send_pixel(8'd200);
    send_pixel(8'd100);
    drain_results();
    // zero width and height act as one
    reg_write(REG_SRC_WIDTH, 32'd0);
    reg_write(REG_SRC_HEIGHT, 32'd0);
    send_pixel(8'd42);
    drain_results();

    // oversized region clamps; a partial first row gives nothing
    no_idle = 1'b1;
    reg_write(REG_SRC_WIDTH, 32'd4095);
    reg_write(REG_SRC_HEIGHT, 32'd8191);
    reg_write(REG_ODD_START, 32'd1);
    send_random(40);
    drain_results();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      w_pick  = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(13, 64))
                                            : 12'($urandom_range(0, 12));
      h_pick  = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(9, 24))
                                            : 13'($urandom_range(0, 8));
      if ($urandom_range(0, 2) != 0) reg_write(REG_SRC_WIDTH, 32'(w_pick));
      if ($urandom_range(0, 2) != 0) reg_write(REG_SRC_HEIGHT, 32'(h_pick));
      if ($urandom_range(0, 2) != 0) reg_write(REG_ODD_START, 32'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) reg_write(REG_UNUSED, $urandom);
      fsize   = sb.frame_size();
      nframes = (fsize > 300) ? 1 : $urandom_range(1, 3);
      count   = fsize * nframes;
      // broken frame: stop partway, the next configuration register write restarts it
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, fsize);
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      send_random(count);
      random_sent += count;
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
